// ===== rtl/ssdc_pkg.sv =====
package ssdc_pkg;

  localparam int unsigned AngleW     = 9;
  localparam int unsigned PulseW     = 13;
  localparam int unsigned DutyW      = 7;
  localparam int unsigned IvlW       = 14;
  localparam int unsigned PeriodW    = 16;
  localparam int unsigned DvdW       = 20;
  localparam int unsigned DivCntW    = 5;
  localparam int unsigned RecipW     = 18;
  localparam int unsigned RecipShift = 24;

  localparam logic [1:0] OP_MOVE  = 2'd0;
  localparam logic [1:0] OP_SWEEP = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [PeriodW-1:0] PERIOD_RESET = 16'd5000;
  localparam logic [AngleW-1:0]  ANGLE_RESET  = 9'd20;
  localparam logic [AngleW-1:0]  TURN_RESET   = 9'd360;
  localparam logic [AngleW-1:0]  ANGLE_MID    = 9'd90;
  localparam logic [PulseW-1:0]  PULSE_MID    = 13'd1500;
  // ceil(2^24 / 97): exact floor divide by 97 for any dividend below 2^24
  localparam logic [RecipW-1:0]  PULSE_RECIP  = 18'd172961;
  localparam logic [DutyW-1:0]   DUTY_MAX     = 7'd100;

  typedef struct packed {
    logic exec;       // apply the accepted item to the state
    logic cap_dvd;    // store the pulse dividend
    logic cap_pulse;  // store the pulse from the reciprocal product
    logic div_start;  // launch the duty divider
    logic cap_duty;   // store the duty from the quotient
  } dp_cmd_t;

  typedef struct packed {
    logic emit;       // the item at the input produces a result
    logic div_done;   // quotient is valid this cycle
  } dp_sts_t;

endpackage

// ===== rtl/servo_sweep_duty_controller_unit.sv =====
// Servo sweep duty controller. Items carry an opcode: move once, start sweep,
// or a one-millisecond tick. A move, and a tick on which a sweep step falls,
// produce one result (angle, pulse width in microseconds, duty percent); the
// other items produce none and are absorbed without leaving idle. For a
// result, the PDVD and PMUL states form the pulse width with a reciprocal
// multiply for the divide by 97, then a 20-bit restoring divider takes the
// duty over the PWM period at one quotient bit per cycle (load, run,
// capture) before out_valid_o. One item is in flight at a time; in_ready_o
// returns the cycle after the result is taken. Write the PWM period only
// while the block is idle.
module servo_sweep_duty_controller_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ssdc_pkg::PeriodW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   opcode_i,
  input  logic [ssdc_pkg::AngleW-1:0]  target_degree_i,
  input  logic [ssdc_pkg::AngleW-1:0]  end_degree_i,
  input  logic [ssdc_pkg::IvlW-1:0]    step_interval_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ssdc_pkg::AngleW-1:0]  angle_o,
  output logic [ssdc_pkg::PulseW-1:0]  pulse_us_o,
  output logic [ssdc_pkg::DutyW-1:0]   duty_percent_o
);
  import ssdc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ssdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ssdc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .opcode_i           (opcode_i),
    .target_degree_i    (target_degree_i),
    .end_degree_i       (end_degree_i),
    .step_interval_ms_i (step_interval_ms_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .angle_o            (angle_o),
    .pulse_us_o         (pulse_us_o),
    .duty_percent_o     (duty_percent_o)
  );

endmodule

// ===== rtl/ssdc_div.sv =====
module ssdc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ssdc_pkg::DvdW-1:0]    dividend_i,
  input  logic [ssdc_pkg::PeriodW-1:0] divisor_i,
  output logic                        done_o,
  output logic [ssdc_pkg::DvdW-1:0]    quotient_o
);
  import ssdc_pkg::*;

  logic                run_q, run_d;
  logic                done_q, done_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [DvdW-1:0]     dvd_q, dvd_d;
  logic [PeriodW-1:0]  rem_q, rem_d;
  logic [PeriodW-1:0]  dsr_q, dsr_d;
  logic [PeriodW:0]    rem_sh;
  logic                ge;

  assign rem_sh = {rem_q, dvd_q[DvdW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      dvd_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
    end else if (run_q) begin
      // one quotient bit per cycle, restoring
      rem_d = ge ? PeriodW'(rem_sh - {1'b0, dsr_q}) : rem_sh[PeriodW-1:0];
      dvd_d = {dvd_q[DvdW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DvdW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ===== rtl/ssdc_dp.sv =====
module ssdc_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ssdc_pkg::PeriodW-1:0] cfg_data_i,
  input  logic [1:0]                   opcode_i,
  input  logic [ssdc_pkg::AngleW-1:0]  target_degree_i,
  input  logic [ssdc_pkg::AngleW-1:0]  end_degree_i,
  input  logic [ssdc_pkg::IvlW-1:0]    step_interval_ms_i,
  input  ssdc_pkg::dp_cmd_t            cmd_i,
  output ssdc_pkg::dp_sts_t            sts_o,
  output logic [ssdc_pkg::AngleW-1:0]  angle_o,
  output logic [ssdc_pkg::PulseW-1:0]  pulse_us_o,
  output logic [ssdc_pkg::DutyW-1:0]   duty_percent_o
);
  import ssdc_pkg::*;

  localparam int unsigned ProdW = RecipShift + PulseW;

  logic [PeriodW-1:0] period_q;
  logic [AngleW-1:0]  cur_q, cur_d;
  logic [AngleW-1:0]  turn_q, turn_d;
  logic               up_q, up_d;
  logic               run_q, run_d;
  logic [IvlW-1:0]    ivl_q, ivl_d;
  logic [IvlW-1:0]    ticks_q, ticks_d;
  logic [DvdW-1:0]    pdvd_q;
  logic [PulseW-1:0]  pulse_q;
  logic [DutyW-1:0]   duty_q;

  logic               step_due;
  logic               up_n;
  logic               below_mid;
  logic [AngleW-1:0]  diff;
  logic [DvdW-1:0]    dvd_pulse;
  logic [ProdW-1:0]   pprod;
  logic [PulseW-1:0]  poff;
  logic [DvdW-1:0]    dvd_duty;
  logic               div_done;
  logic [DvdW-1:0]    quot;

  assign step_due = run_q && (ticks_q <= IvlW'(1));
  assign sts_o.emit = (opcode_i == OP_MOVE) || ((opcode_i == OP_TICK) && step_due);
  assign sts_o.div_done = div_done;

  always_comb begin
    cur_d   = cur_q;
    turn_d  = turn_q;
    up_d    = up_q;
    run_d   = run_q;
    ivl_d   = ivl_q;
    ticks_d = ticks_q;
    up_n    = up_q;
    if (cur_q >= turn_q) begin
      up_n = 1'b0;
    end else if (cur_q == '0) begin
      up_n = 1'b1;
    end
    if (cmd_i.exec) begin
      case (opcode_i)
        OP_MOVE: begin
          run_d = 1'b0;
          cur_d = target_degree_i;
        end
        OP_SWEEP: begin
          turn_d  = end_degree_i;
          cur_d   = (target_degree_i > end_degree_i) ? end_degree_i : target_degree_i;
          ivl_d   = (step_interval_ms_i == '0) ? IvlW'(1) : step_interval_ms_i;
          ticks_d = IvlW'(1);
          run_d   = 1'b1;
        end
        OP_TICK: begin
          if (run_q) begin
            if (!step_due) begin
              ticks_d = ticks_q - 1'b1;
            end else begin
              ticks_d = ivl_q;
              // bounce between zero and the turning angle
              if (turn_q == '0) begin
                cur_d = '0;
                up_d  = 1'b0;
              end else begin
                up_d  = up_n;
                cur_d = up_n ? cur_q + 1'b1 : cur_q - 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // pulse: 1500 -/+ (|a-90| * 1000 / 97), offset rounded up below 90 degrees
  // and down above; the divide by 97 is a multiply by the scaled reciprocal
  assign below_mid = cur_q <= ANGLE_MID;
  assign diff      = below_mid ? ANGLE_MID - cur_q : cur_q - ANGLE_MID;
  assign dvd_pulse = DvdW'(diff) * DvdW'(1000) + (below_mid ? DvdW'(96) : DvdW'(0));
  assign pprod     = ProdW'(pdvd_q) * ProdW'(PULSE_RECIP);
  assign poff      = pprod[ProdW-1:RecipShift];
  assign dvd_duty  = DvdW'(pulse_q) * DvdW'(100);

  ssdc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd_duty),
    .divisor_i  (period_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
      cur_q    <= ANGLE_RESET;
      turn_q   <= TURN_RESET;
      up_q     <= 1'b1;
      run_q    <= 1'b0;
      ivl_q    <= '0;
      ticks_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_data_i;
      end
      cur_q   <= cur_d;
      turn_q  <= turn_d;
      up_q    <= up_d;
      run_q   <= run_d;
      ivl_q   <= ivl_d;
      ticks_q <= ticks_d;
    end
  end

  // a zero period gives an all-ones quotient, which saturates like any overflow
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_dvd) begin
      pdvd_q <= dvd_pulse;
    end
    if (cmd_i.cap_pulse) begin
      pulse_q <= below_mid ? PULSE_MID - poff : PULSE_MID + poff;
    end
    if (cmd_i.cap_duty) begin
      duty_q <= (quot > DvdW'(DUTY_MAX)) ? DUTY_MAX : quot[DutyW-1:0];
    end
  end

  assign angle_o        = cur_q;
  assign pulse_us_o     = pulse_q;
  assign duty_percent_o = duty_q;

endmodule

// ===== rtl/ssdc_ctrl.sv =====
module ssdc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ssdc_pkg::dp_sts_t sts_i,
  output ssdc_pkg::dp_cmd_t cmd_o
);
  import ssdc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PDVD   = 3'd1;
  localparam logic [2:0] S_PMUL   = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DWAIT  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = state_q == S_OUT;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.exec      = accept;
    case (state_q)
      S_IDLE: begin
        if (accept && sts_i.emit) begin
          state_d = S_PDVD;
        end
      end
      S_PDVD: begin
        cmd_o.cap_dvd = 1'b1;
        state_d       = S_PMUL;
      end
      S_PMUL: begin
        cmd_o.cap_pulse = 1'b1;
        state_d         = S_DSTART;
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.cap_duty = 1'b1;
          state_d        = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import ssdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  localparam int unsigned MID_DEG      = 90;
  localparam int unsigned MID_PULSE_US = 1500;
  localparam int unsigned SLOPE_DEN    = 97;
  localparam int unsigned DUTY_CEIL    = 100;

  typedef struct packed {
    logic [AngleW-1:0] angle;
    logic [PulseW-1:0] pulse;
    logic [DutyW-1:0]  duty;
  } servo_cmd_t;

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                cfg_we_i           = 1'b0;
  logic [PeriodW-1:0]  cfg_data_i         = '0;
  logic                in_valid_i         = 1'b0;
  logic                in_ready_o;
  logic [1:0]          opcode_i           = OP_MOVE;
  logic [AngleW-1:0]   target_degree_i    = '0;
  logic [AngleW-1:0]   end_degree_i       = '0;
  logic [IvlW-1:0]     step_interval_ms_i = '0;
  logic                out_valid_o;
  logic                out_ready_i        = 1'b0;
  logic [AngleW-1:0]   angle_o;
  logic [PulseW-1:0]   pulse_us_o;
  logic [DutyW-1:0]    duty_percent_o;

  // servo model state
  logic [PeriodW-1:0]  period_us;
  logic [AngleW-1:0]   angle_deg;
  logic [AngleW-1:0]   turn_deg;
  logic                heading_up;
  logic                sweeping;
  logic [IvlW-1:0]     step_ms;
  logic [IvlW-1:0]     ms_to_step;
  bit                  item_was_ignored;

  servo_cmd_t          expected_cmds[$];
  servo_cmd_t          want_cmd;

  int unsigned         send_idle_pct;
  int unsigned         recv_stall_pct;
  int unsigned         cycle_count;
  int unsigned         errors;
  int unsigned         items_sent;
  int unsigned         items_effective;
  int unsigned         results_checked;
  int unsigned         sweep_steps;
  int unsigned         period_writes;

  servo_sweep_duty_controller_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .target_degree_i    (target_degree_i),
    .end_degree_i       (end_degree_i),
    .step_interval_ms_i (step_interval_ms_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .angle_o            (angle_o),
    .pulse_us_o         (pulse_us_o),
    .duty_percent_o     (duty_percent_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_cmds.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic logic [PulseW-1:0] pulse_for_angle(input logic [AngleW-1:0] a);
    int unsigned deg;
    int unsigned off_us;
    deg = int'(a);
    if (deg <= MID_DEG) begin
      // round the offset up below mid travel
      off_us = ((MID_DEG - deg) * 1000 + SLOPE_DEN - 1) / SLOPE_DEN;
      return PulseW'(MID_PULSE_US - off_us);
    end
    off_us = ((deg - MID_DEG) * 1000) / SLOPE_DEN;
    return PulseW'(MID_PULSE_US + off_us);
  endfunction

  function automatic servo_cmd_t command_for_angle(input logic [AngleW-1:0] a);
    servo_cmd_t  cmd;
    int unsigned duty;
    cmd.angle = a;
    cmd.pulse = pulse_for_angle(a);
    if (period_us == '0) begin
      duty = DUTY_CEIL;
    end else begin
      duty = (int'(cmd.pulse) * 100) / int'(period_us);
      if (duty > DUTY_CEIL) duty = DUTY_CEIL;
    end
    cmd.duty = DutyW'(duty);
    return cmd;
  endfunction

  function automatic void advance_servo(input logic [1:0] op, input logic [AngleW-1:0] tgt,
                                        input logic [AngleW-1:0] endd,
                                        input logic [IvlW-1:0] ivl);
    item_was_ignored = 1'b0;
    case (op)
      OP_MOVE: begin
        sweeping  = 1'b0;
        angle_deg = tgt;
        expected_cmds.push_back(command_for_angle(angle_deg));
      end
      OP_SWEEP: begin
        turn_deg   = endd;
        angle_deg  = (tgt > endd) ? endd : tgt;
        step_ms    = (ivl == '0) ? IvlW'(1) : ivl;
        ms_to_step = IvlW'(1);
        sweeping   = 1'b1;
      end
      OP_TICK: begin
        if (!sweeping) begin
          item_was_ignored = 1'b1;
        end else if (ms_to_step > IvlW'(1)) begin
          ms_to_step = ms_to_step - 1'b1;
        end else begin
          // bounce one degree between zero and the turning angle
          if (turn_deg == '0) begin
            angle_deg  = '0;
            heading_up = 1'b0;
          end else begin
            if (angle_deg >= turn_deg) heading_up = 1'b0;
            else if (angle_deg == '0) heading_up = 1'b1;
            angle_deg = heading_up ? angle_deg + 1'b1 : angle_deg - 1'b1;
          end
          ms_to_step = step_ms;
          sweep_steps++;
          expected_cmds.push_back(command_for_angle(angle_deg));
        end
      end
      default: item_was_ignored = 1'b1;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_cmds.size() == 0) begin
        $display("%0t: unexpected result angle %0d pulse %0d duty %0d", $time,
                 angle_o, pulse_us_o, duty_percent_o);
        errors++;
      end else begin
        want_cmd = expected_cmds.pop_front();
        results_checked++;
        if (angle_o !== want_cmd.angle) begin
          $display("%0t: angle expected %0d actual %0d", $time, want_cmd.angle, angle_o);
          errors++;
        end
        if (pulse_us_o !== want_cmd.pulse) begin
          $display("%0t: pulse_us expected %0d actual %0d (angle %0d)", $time,
                   want_cmd.pulse, pulse_us_o, want_cmd.angle);
          errors++;
        end
        if (duty_percent_o !== want_cmd.duty) begin
          $display("%0t: duty_percent expected %0d actual %0d (pulse %0d, period %0d)",
                   $time, want_cmd.duty, duty_percent_o, want_cmd.pulse, period_us);
          errors++;
        end
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [AngleW-1:0] tgt,
                           input logic [AngleW-1:0] endd, input logic [IvlW-1:0] ivl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    opcode_i           <= op;
    target_degree_i    <= tgt;
    end_degree_i       <= endd;
    step_interval_ms_i <= ivl;
    do @(posedge clk_i); while (!in_ready_o);
    advance_servo(op, tgt, endd, ivl);
    items_sent++;
    if (!item_was_ignored) items_effective++;
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_cmds.size() != 0);
  endtask

  task automatic drain_and_settle();
    wait_for_drain();
    // a trailing item with no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [PeriodW-1:0] value);
    drain_and_settle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    period_us = value;
    period_writes++;
  endtask

  function automatic logic [AngleW-1:0] pick_angle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return AngleW'($urandom_range(0, 4));
    if (r < 85) return AngleW'($urandom_range(0, 360));
    return AngleW'($urandom);
  endfunction

  function automatic logic [IvlW-1:0] pick_interval();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return '0;
    if (r < 75) return IvlW'($urandom_range(1, 4));
    if (r < 95) return IvlW'($urandom_range(5, 40));
    return IvlW'($urandom);
  endfunction

  function automatic logic [PeriodW-1:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return PeriodW'(1000);
    if (r < 30) return PeriodW'(65535);
    if (r < 40) return PeriodW'($urandom_range(0, 999));
    return PeriodW'($urandom_range(1000, 65535));
  endfunction

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // pulse formula edges and out-of-range angles
    send_item(OP_MOVE, 9'd0, 9'd0, 14'd0);
    send_item(OP_MOVE, 9'd90, 9'd0, 14'd0);
    send_item(OP_MOVE, 9'd91, 9'd0, 14'd0);
    send_item(OP_MOVE, 9'd89, 9'd0, 14'd0);
    send_item(OP_MOVE, 9'd1, 9'd0, 14'd0);
    send_item(OP_MOVE, 9'd180, 9'd0, 14'd0);
    send_item(OP_MOVE, 9'd360, 9'd0, 14'd0);
    send_item(OP_MOVE, 9'd511, 9'h1FF, 14'h3FFF);
    // ignored items
    send_item(OP_UNUSED, 9'h1FF, 9'h1FF, 14'h3FFF);
    send_item(OP_TICK, 9'd10, 9'd20, 14'd3);
    // start above end clamps, zero interval steps every tick
    send_item(OP_SWEEP, 9'd200, 9'd100, 14'd0);
    send_item(OP_TICK, 9'd0, 9'd0, 14'd0);
    send_item(OP_TICK, 9'd0, 9'd0, 14'd0);
    // end of zero pins the angle at zero
    send_item(OP_SWEEP, 9'd0, 9'd0, 14'd1);
    send_item(OP_TICK, 9'd0, 9'd0, 14'd0);
    send_item(OP_TICK, 9'd0, 9'd0, 14'd0);
    // direction carries over a new sweep start; longest interval
    send_item(OP_SWEEP, 9'd5, 9'd2, 14'h3FFF);
    send_item(OP_TICK, 9'd0, 9'd0, 14'd0);
    send_item(OP_TICK, 9'd0, 9'd0, 14'd0);
    // bounce off zero and step every second tick
    send_item(OP_SWEEP, 9'd1, 9'd360, 14'd2);
    send_item(OP_TICK, 9'd0, 9'd0, 14'd0);
    send_item(OP_TICK, 9'd0, 9'd0, 14'd0);
    send_item(OP_TICK, 9'd0, 9'd0, 14'd0);
    // move cancels the sweep
    send_item(OP_MOVE, 9'd45, 9'd0, 14'd0);
    send_item(OP_TICK, 9'd0, 9'd0, 14'd0);
  endtask

  task automatic test_period_settings();
    logic [PeriodW-1:0] periods[7];
    periods = '{16'd1000, 16'd65535, 16'd0, 16'd1, 16'd97, 16'd4283, 16'd5000};
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    foreach (periods[i]) begin
      write_period(periods[i]);
      send_item(OP_MOVE, 9'd0, 9'd0, 14'd0);
      send_item(OP_MOVE, 9'd90, 9'd0, 14'd0);
      send_item(OP_MOVE, 9'd360, 9'd0, 14'd0);
      send_item(OP_MOVE, pick_angle(), 9'd0, 14'd0);
    end
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned n_items);
    int unsigned start_count;
    int unsigned kind;
    bit          paused;
    write_period(pick_period());
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start_count    = items_effective;
    paused         = 1'b0;
    while (items_effective - start_count < n_items) begin
      if (!paused && items_effective - start_count >= n_items / 2) begin
        // hold off until the block has handed over every pending result
        wait_for_drain();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        send_item(OP_SWEEP, pick_angle(), pick_angle(), pick_interval());
        repeat ($urandom_range(1, 30))
          send_item(OP_TICK, AngleW'($urandom), AngleW'($urandom), IvlW'($urandom));
      end else if (kind < 75) begin
        send_item(OP_MOVE, pick_angle(), AngleW'($urandom), IvlW'($urandom));
      end else if (kind < 88) begin
        repeat ($urandom_range(1, 4))
          send_item(OP_TICK, AngleW'($urandom), AngleW'($urandom), IvlW'($urandom));
      end else begin
        send_item(2'($urandom), AngleW'($urandom), AngleW'($urandom), IvlW'($urandom));
      end
    end
  endtask

  initial begin
    period_us        = PERIOD_RESET;
    angle_deg        = ANGLE_RESET;
    turn_deg         = TURN_RESET;
    heading_up       = 1'b1;
    sweeping         = 1'b0;
    step_ms          = '0;
    ms_to_step       = '0;
    item_was_ignored = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    cycle_count      = 0;
    errors           = 0;
    items_sent       = 0;
    items_effective  = 0;
    results_checked  = 0;
    sweep_steps      = 0;
    period_writes    = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_period_settings();
    test_random_traffic(0, 0, 300);
    test_random_traffic(74, 0, 300);
    test_random_traffic(0, 74, 300);
    test_random_traffic(21, 21, 300);
    drain_and_settle();

    $display("Sent %0d items (%0d acted on), checked %0d results incl. %0d sweep steps,",
             items_sent, items_effective, results_checked, sweep_steps);
    $display("across %0d PWM period writes and four sender/receiver stall mixes.",
             period_writes);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ssdc_pkg.sv
rtl/ssdc_div.sv
rtl/ssdc_dp.sv
rtl/ssdc_ctrl.sv
rtl/servo_sweep_duty_controller_unit.sv
verif/testbench.sv
